/* sv/uvma_pkg.sv */
`timescale 1ns / 1ps

package uvma_pkg;

    // Field widths
    localparam int RAW_W  = 12;
    localparam int UV_W   = 22;
    localparam int FRAC_W = 16;
    localparam int FILL_W = 5;
    localparam int ACT_W  = 2;

    // Serial divider: remainder/divisor width; covers 4095 and any count up to 4095
    localparam int DIV_W = 12;

    localparam int WINDOW_DEF = 16;

    // UV index = raw * 33 / 4095, Q16, rounded: (raw*33*2^16 + 2047) / 4095
    localparam logic [RAW_W-1:0]  ADC_FULL = 12'd4095;
    localparam logic [FRAC_W-1:0] ROUND_LO = 16'h07FF;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CONV  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

endpackage

/* sv/uv_index_moving_average_core.sv */
`timescale 1ns / 1ps

// UV index converter with a boxcar moving average over WINDOW samples.
//
// Input channel: in_valid / in_stall with action and raw_sample. A word is
// taken when in_valid is high and in_stall is low. Action add pushes the
// converted sample into the window, clear empties it, convert (and the
// unused code) only converts.
// Output channel: out_valid / out_stall with sample_uv, average_uv and
// fill_count, one word per input word, held steady while stalled.
// Timing: one shared restoring divider produces one quotient bit per cycle,
// 22 bits per division. An item runs accept, conversion (/4095), window
// update (subtract oldest, then add newest), mean (sum / count) and a
// final step to load the output register; the next word is taken only
// after that load. When the window ends up empty the mean division is
// skipped.
// The output register frees the core, so the next word is accepted while a
// result still waits on out_stall; a second finished result waits in the
// core, with in_stall high, until the output register drains.
// Reset empties the window (count, sum and write slot to zero) and drops any
// pending result; unfilled ring slots are never used, so they are not cleared.

module uv_index_moving_average_core
    import uvma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [RAW_W-1:0]  raw_sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [UV_W-1:0]   sample_uv,
    output logic [UV_W-1:0]   average_uv,
    output logic [FILL_W-1:0] fill_count
);

    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    // sum < WINDOW * 2^22, high part kept at least one bit wide
    localparam int SUM_HI_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W    = UV_W + SUM_HI_W;
    localparam int BIT_W    = $clog2(UV_W);
    localparam int MUL_W    = RAW_W + 6;   // raw * 33

    localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(UV_W - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_SUB  = 6'b000100,
        S_ADD  = 6'b001000,
        S_MEAN = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [UV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]    dvs_reg, dvs_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [UV_W-1:0]     uv_reg, uv_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [UV_W-1:0]     sample_uv_reg, sample_uv_next;
    logic [UV_W-1:0]     average_uv_reg, average_uv_next;
    logic [FILL_W-1:0]   fill_count_reg, fill_count_next;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [UV_W-1:0]     ram_rd_data;

    logic [MUL_W-1:0]    raw33;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                ge;
    logic [DIV_W-1:0]    step_rem;
    logic [UV_W-1:0]     step_quo;
    logic                full;
    logic [CNT_W+FILL_W-1:0] count_ext;

    // Ring of converted samples; the slot about to be overwritten is read at accept
    uvma_ram #(
        .DATA_W (UV_W),
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (uv_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    // raw * 33 = raw * 32 + raw
    assign raw33 = MUL_W'({raw_sample, 5'b0}) + MUL_W'(raw_sample);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[UV_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign step_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    assign step_quo = {quo_reg[UV_W-2:0], ge};

    assign full      = (count_reg == CNT_FULL);
    assign count_ext = {{FILL_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        bit_next        = bit_reg;
        uv_next         = uv_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg & out_stall;
        sample_uv_next  = sample_uv_reg;
        average_uv_next = average_uv_reg;
        fill_count_next = fill_count_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    // dividend = {raw33, 2047 in 16 bits}; top 12 bits seed the remainder
                    rem_next   = raw33[MUL_W-1:UV_W-FRAC_W];
                    quo_next   = {raw33[UV_W-FRAC_W-1:0], ROUND_LO};
                    dvs_next   = ADC_FULL;
                    bit_next   = '0;
                    ram_rd_en  = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                rem_next = step_rem;
                quo_next = step_quo;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_LAST)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                uv_next = quo_reg;
                // full window: drop the oldest entry, which sits at the write slot
                if (act_reg == ACT_ADD && full)
                begin
                    sum_next = sum_reg - {{SUM_HI_W{1'b0}}, ram_rd_data};
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        sum_next  = sum_reg + {{SUM_HI_W{1'b0}}, uv_reg};
                        ram_wr_en = 1'b1;
                        if (!full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
                    end
                    ACT_CLEAR:
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        slot_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
                // mean < 2^22, so sum >> 22 < count: high part seeds the remainder
                rem_next = {{(DIV_W-SUM_HI_W){1'b0}}, sum_next[SUM_W-1:UV_W]};
                quo_next = sum_next[UV_W-1:0];
                dvs_next = {{(DIV_W-CNT_W){1'b0}}, count_next};
                bit_next = '0;
                state_next = (count_next == '0) ? S_FIN : S_MEAN;
            end
            S_MEAN:
            begin
                rem_next = step_rem;
                quo_next = step_quo;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    sample_uv_next  = uv_reg;
                    average_uv_next = (count_reg == '0) ? '0 : quo_reg;
                    fill_count_next = count_ext[FILL_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        bit_reg        <= bit_next;
        uv_reg         <= uv_next;
        sample_uv_reg  <= sample_uv_next;
        average_uv_reg <= average_uv_next;
        fill_count_reg <= fill_count_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_uv  = sample_uv_reg;
    assign average_uv = average_uv_reg;
    assign fill_count = fill_count_reg;

    // Assertions

    // a result appears only from the finish step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("out_valid rose outside finish step");

    // window never holds more than WINDOW entries
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("fill count above window size");

    // divider partial remainder stays below divisor, or quotient overflows 22 bits
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV || state_reg == S_MEAN) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // a full window can only stay full or be cleared
    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> (count_reg == CNT_FULL || count_reg == '0))
        else $error("full window lost entries without clear");

endmodule

/* sv/uvma_ram.sv */
`timescale 1ns / 1ps

module uvma_ram #(
    parameter int DATA_W = 22,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

// UV index / boxcar average check: every accepted input word is pushed
// through a local copy of the window arithmetic, and every output word is
// compared against the oldest prediction still waiting.

module testbench;
    import uvma_pkg::*;

    // The fourth action code has no name in the package; the block treats it
    // as convert only.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 60;    // a bit over one item that runs both divisions
    localparam int LONG_HOLD    = 400;    // output stall long enough to back up the core
    localparam int REPORT_MAX   = 10;
    localparam longint unsigned UV_SCALE = 64'd2162688;    // 33 * 2^16

    // Window state mirror plus the queue of result words not yet seen.
    class uv_window_scoreboard;
        typedef struct packed {
            logic [UV_W-1:0]   sample_uv;
            logic [UV_W-1:0]   average_uv;
            logic [FILL_W-1:0] fill_count;
        } uv_word_t;

        logic [UV_W-1:0] ring [WINDOW_DEF];
        int unsigned     slot;
        int unsigned     held;
        longint unsigned sum;
        uv_word_t        pending_words [$];
        int              mismatches;

        function new();
            slot       = 0;
            held       = 0;
            sum        = 0;
            mismatches = 0;
        endfunction

        // Rounded Q16 of raw * 3.3 * 10 / 4095
        function logic [UV_W-1:0] uv_index(logic [RAW_W-1:0] raw);
            longint unsigned num;
            num = 64'(raw) * UV_SCALE + 64'(ROUND_LO);
            return UV_W'(num / 64'(ADC_FULL));
        endfunction

        function void note_sample(logic [ACT_W-1:0] act, logic [RAW_W-1:0] raw);
            uv_word_t        w;
            logic [UV_W-1:0] uv;
            uv = uv_index(raw);
            if (act == ACT_ADD)
            begin
                // full window: slot points at the oldest entry
                if (held < WINDOW_DEF)
                    held++;
                else
                    sum -= ring[slot];
                sum += uv;
                ring[slot] = uv;
                slot = (slot + 1) % WINDOW_DEF;
            end
            else if (act == ACT_CLEAR)
            begin
                slot = 0;
                held = 0;
                sum  = 0;
            end
            w.sample_uv  = uv;
            w.average_uv = (held != 0) ? UV_W'(sum / held) : '0;
            w.fill_count = FILL_W'(held);
            pending_words.push_back(w);
        endfunction

        function void check_result(logic [UV_W-1:0] s_uv, logic [UV_W-1:0] a_uv,
                                   logic [FILL_W-1:0] fill);
            uv_word_t want;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: sample_uv %0d average_uv %0d fill_count %0d",
                             s_uv, a_uv, fill);
                return;
            end
            want = pending_words.pop_front();
            if (s_uv !== want.sample_uv || a_uv !== want.average_uv
                || fill !== want.fill_count)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("word mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             want.sample_uv, want.average_uv, want.fill_count,
                             s_uv, a_uv, fill);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ACT_W-1:0]  action;
    logic [RAW_W-1:0]  raw_sample;
    logic              out_valid;
    logic              out_stall;
    logic [UV_W-1:0]   sample_uv;
    logic [UV_W-1:0]   average_uv;
    logic [FILL_W-1:0] fill_count;

    uv_window_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;    // bumped by the stimulus side
    int hold_served   = 0;    // owned by the output side
    int hold_left     = 0;
    int cycles        = 0;

    uv_index_moving_average_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_uv  (sample_uv),
        .average_uv (average_uv),
        .fill_count (fill_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: values read right after the edge are the ones the edge
    // sampled, so a word counts as taken exactly when the block saw it taken.
    // A requested long hold overrides the random stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(sample_uv, average_uv, fill_count);
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one word, with random idle cycles first. in_valid stays high from
    // one word to the next when no gap is drawn, so it never gets two updates
    // in one step.
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        raw_sample <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(act, raw);
    endtask

    // Drop valid and wait for every predicted word to come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Mostly adds so the window fills and wraps; clears are rare enough that
    // a full window is the common case between them.
    task automatic send_random(input int count);
        logic [ACT_W-1:0] act;
        logic [RAW_W-1:0] raw;
        int               pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
                act = ACT_ADD;
            else if (pick < 90)
                act = ACT_CONV;
            else if (pick < 96)
                act = ACT_UNUSED;
            else
                act = ACT_CLEAR;
            case ($urandom_range(9))
                0:       raw = '0;
                1:       raw = '1;
                default: raw = RAW_W'($urandom_range(4095));
            endcase
            send_word(act, raw);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_ADD;
        raw_sample = '0;
        out_stall  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range ends, every action, the unused code, clear of an
        // empty window, then enough adds to fill the window and wrap it.
        send_word(ACT_CONV, '0);
        send_word(ACT_CONV, '1);
        send_word(ACT_UNUSED, '1);
        send_word(ACT_UNUSED, '0);
        send_word(ACT_CLEAR, '1);
        send_word(ACT_ADD, '1);
        send_word(ACT_ADD, '0);
        send_word(ACT_CONV, 12'd2048);
        for (int i = 0; i < 16; i++)
            send_word(ACT_ADD, (i % 3 == 0) ? 12'hFFF : RAW_W'(i * 255));
        send_word(ACT_CLEAR, 12'hAAA);
        wait_drained();

        // Busy sender, slow receiver.
        send_idle_pct = 38;
        recv_idle_pct = 68;
        send_random(150);
        wait_drained();

        // Slow sender, busy receiver.
        send_idle_pct = 68;
        recv_idle_pct = 38;
        send_random(150);
        wait_drained();

        // Full rate, opening with a long output hold so input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        send_random(150);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
